[sv/gccs_pkg.sv]
package gccs_pkg;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 10;

  localparam logic [6:0] DIM_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic REG_GRID_HEIGHT = 1'b0;
  localparam logic REG_GRID_WIDTH  = 1'b1;

  // Input word function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Row and column offsets of the eight neighbors, clockwise from upper left.
  function automatic logic signed [1:0] row_step(input logic [2:0] d);
    logic signed [1:0] s;
    case (d)
      3'd0, 3'd1, 3'd2: s = -2'sd1;
      3'd3, 3'd7:       s = 2'sd0;
      default:          s = 2'sd1;
    endcase
    return s;
  endfunction

  function automatic logic signed [1:0] col_step(input logic [2:0] d);
    logic signed [1:0] s;
    case (d)
      3'd0, 3'd6, 3'd7: s = -2'sd1;
      3'd1, 3'd5:       s = 2'sd0;
      default:          s = 2'sd1;
    endcase
    return s;
  endfunction

endpackage

[sv/gccs_ram.sv]
module gccs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  waddr,
  input  logic [W-1:0]                          wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  raddr,
  output logic [W-1:0]                          rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/grid_component_size_census.sv]
// Load word: busy stays low while the grid fills (one pixel per cycle). The word that
// completes it starts labelling: a pass clearing the visited map over h*w cells, a raster
// scan in which each unvisited pixel seeds a queued walk of the eight neighbors (a probe
// outside the grid skips the memory read) recording each region's value and size, then
// an insertion sort of the region list. Fetch word: result in the cycle after acceptance,
// busy in that cycle; results cannot be stalled. Synchronous active-low reset sets state,
// phase, dims, load/count/fetch, out_valid; other registers, memories hold no reset value.
module grid_component_size_census #(
  parameter int MAX_ROWS   = gccs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = gccs_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = gccs_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [9:0]  in_pixel_value,
  output logic        out_valid,
  output logic [9:0]  out_region_value,
  output logic [12:0] out_region_size,
  output logic        out_last_pair,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DRW   = $clog2(MAX_ROWS + 1);
  localparam int DCW   = $clog2(MAX_COLS + 1);
  localparam int VB    = VALUE_BITS;
  localparam int LW    = VB + CW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FOUT, ST_CLR, ST_SRD, ST_SCHK, ST_PRD, ST_PWT,
    ST_NB, ST_NCHK, ST_REC, ST_IRD, ST_IWT, ST_JRD, ST_JWT
  } state_t;

  // Clamp a written dimension into 1..mx.
  function automatic logic [7:0] clamp_dim(input logic [6:0] v, input int mx);
    logic [7:0] r;
    if (v == 7'd0) begin
      r = 8'd1;
    end else if (int'(v) > mx) begin
      r = 8'(mx);
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  state_t          state_r, state_nxt;
  logic            results_r, results_nxt;   // Phase: high while pairs are fetched.
  logic [DRW-1:0]  h_r, h_nxt, lh_r, lh_nxt;
  logic [DCW-1:0]  w_r, w_nxt, lw_r, lw_nxt;
  logic [CW-1:0]   load_r, load_nxt, n_r, n_nxt, s_r, s_nxt;
  logic [CW-1:0]   head_r, head_nxt, tail_r, tail_nxt, count_r, count_nxt;
  logic [CW-1:0]   i_r, i_nxt, j_r, j_nxt, fetch_r, fetch_nxt;
  logic [RW-1:0]   sr_r, sr_nxt, cur_r_r, cur_r_nxt;
  logic [CLW-1:0]  sc_r, sc_nxt, cur_c_r, cur_c_nxt;
  logic [2:0]      d_r, d_nxt;
  logic [VB-1:0]   v_r, v_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [RW-1:0]   nr_keep_r, nr_keep_nxt;
  logic [CLW-1:0]  nc_keep_r, nc_keep_nxt;
  logic [LW-1:0]   key_r, key_nxt;
  logic            out_valid_r, out_valid_nxt, last_r, last_nxt;

  // Memory ports.
  logic            pix_we, vis_we, vis_wdata, q_we, l_we;
  logic [AW-1:0]   pix_waddr, vis_waddr, q_waddr, q_raddr, l_waddr, l_raddr, rd_addr;
  logic [VB-1:0]   pix_rdata;
  logic            vis_rdata;
  logic [RW+CLW-1:0] q_wdata, q_rdata;
  logic [LW-1:0]   l_wdata, l_rdata;

  // Neighbor address generation: the one shared offset, bounds and index unit.
  logic signed [RW+1:0]  nr_s;
  logic signed [CLW+1:0] nc_s;
  logic                  nb_in;
  logic [AW-1:0]         nb_idx;
  logic [DRW+DCW-1:0]    total;
  logic                  accept;

  assign nr_s  = $signed({2'b00, cur_r_r}) + (RW+2)'(gccs_pkg::row_step(d_r));
  assign nc_s  = $signed({2'b00, cur_c_r}) + (CLW+2)'(gccs_pkg::col_step(d_r));
  assign nb_in = !nr_s[RW+1] && (nr_s[RW:0] < lh_r) && !nc_s[CLW+1] && (nc_s[CLW:0] < lw_r);
  assign nb_idx = AW'(nr_s[RW-1:0]) * AW'(lw_r) + AW'(nc_s[CLW-1:0]);
  assign total  = h_r * w_r;
  assign accept = start && (state_r == ST_IDLE);

  gccs_ram #(.W(VB), .D(CELLS)) u_pix (
    .clk, .we(pix_we), .waddr(pix_waddr), .wdata(VB'(in_pixel_value)),
    .raddr(rd_addr), .rdata(pix_rdata)
  );
  gccs_ram #(.W(1), .D(CELLS)) u_vis (
    .clk, .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(rd_addr), .rdata(vis_rdata)
  );
  gccs_ram #(.W(RW+CLW), .D(CELLS)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  gccs_ram #(.W(LW), .D(CELLS)) u_list (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    results_nxt = results_r;
    h_nxt = h_r;  w_nxt = w_r;  lh_nxt = lh_r;  lw_nxt = lw_r;
    load_nxt = load_r;  n_nxt = n_r;  s_nxt = s_r;
    head_nxt = head_r;  tail_nxt = tail_r;  count_nxt = count_r;
    i_nxt = i_r;  j_nxt = j_r;  fetch_nxt = fetch_r;
    sr_nxt = sr_r;  sc_nxt = sc_r;  cur_r_nxt = cur_r_r;  cur_c_nxt = cur_c_r;
    d_nxt = d_r;  v_nxt = v_r;  idx_nxt = idx_r;
    nr_keep_nxt = nr_keep_r;  nc_keep_nxt = nc_keep_r;
    key_nxt = key_r;  last_nxt = last_r;
    out_valid_nxt = 1'b0;

    pix_we = 1'b0;  pix_waddr = load_r[AW-1:0];
    vis_we = 1'b0;  vis_waddr = s_r[AW-1:0];  vis_wdata = 1'b1;
    q_we = 1'b0;  q_waddr = tail_r[AW-1:0];  q_wdata = {nr_keep_r, nc_keep_r};
    q_raddr = head_r[AW-1:0];
    l_we = 1'b0;  l_waddr = count_r[AW-1:0];  l_wdata = {v_r, tail_r};
    l_raddr = fetch_r[AW-1:0];
    rd_addr = s_r[AW-1:0];

    if (cfg_we) begin
      if (cfg_index == gccs_pkg::REG_GRID_HEIGHT) begin
        h_nxt = DRW'(clamp_dim(cfg_wdata, MAX_ROWS));
      end else begin
        w_nxt = DCW'(clamp_dim(cfg_wdata, MAX_COLS));
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func == gccs_pkg::FUNC_LOAD && !results_r) begin
          if (load_r < CW'(total)) begin
            pix_we   = 1'b1;
            load_nxt = load_r + 1'b1;
          end
          // The word that fills the grid, or finds it already full, starts labelling.
          if (load_r + 1'b1 >= CW'(total)) begin
            lh_nxt    = h_r;
            lw_nxt    = w_r;
            n_nxt     = CW'(total);
            s_nxt     = '0;
            state_nxt = ST_CLR;
          end
        end else if (accept && in_func == gccs_pkg::FUNC_FETCH && results_r) begin
          out_valid_nxt = 1'b1;
          last_nxt      = (fetch_r + 1'b1 == count_r);
          fetch_nxt     = fetch_r + 1'b1;
          if (fetch_r + 1'b1 == count_r) begin
            results_nxt = 1'b0;
            load_nxt    = '0;
            fetch_nxt   = '0;
            count_nxt   = '0;
          end
          state_nxt = ST_FOUT;
        end
      end
      ST_FOUT: begin
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        vis_we    = 1'b1;
        vis_wdata = 1'b0;
        if (s_r + 1'b1 == n_r) begin
          s_nxt     = '0;
          sr_nxt    = '0;
          sc_nxt    = '0;
          count_nxt = '0;
          state_nxt = ST_SRD;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      ST_SRD: begin
        state_nxt = ST_SCHK;
      end
      ST_SCHK, ST_REC: begin
        if (state_r == ST_REC) begin
          l_we      = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        if (state_r == ST_SCHK && !vis_rdata) begin
          // New seed: mark it, queue it and start its walk.
          v_nxt     = pix_rdata;
          vis_we    = 1'b1;
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = {sr_r, sc_r};
          head_nxt  = '0;
          tail_nxt  = CW'(1);
          state_nxt = ST_PRD;
        end else if (s_r + 1'b1 == n_r) begin
          i_nxt     = CW'(1);
          state_nxt = ST_IRD;
        end else begin
          s_nxt = s_r + 1'b1;
          if (DCW'(sc_r) + 1'b1 == lw_r) begin
            sc_nxt = '0;
            sr_nxt = sr_r + 1'b1;
          end else begin
            sc_nxt = sc_r + 1'b1;
          end
          state_nxt = ST_SRD;
        end
      end
      ST_PRD: begin
        state_nxt = ST_PWT;
      end
      ST_PWT: begin
        cur_r_nxt = q_rdata[RW+CLW-1:CLW];
        cur_c_nxt = q_rdata[CLW-1:0];
        head_nxt  = head_r + 1'b1;
        d_nxt     = '0;
        state_nxt = ST_NB;
      end
      ST_NB: begin
        if (nb_in) begin
          rd_addr     = nb_idx;
          idx_nxt     = nb_idx;
          nr_keep_nxt = nr_s[RW-1:0];
          nc_keep_nxt = nc_s[CLW-1:0];
          state_nxt   = ST_NCHK;
        end else if (d_r == 3'd7) begin
          state_nxt = (head_r < tail_r) ? ST_PRD : ST_REC;
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      ST_NCHK: begin
        if (!vis_rdata && pix_rdata == v_r) begin
          vis_we    = 1'b1;
          vis_waddr = idx_r;
          q_we      = 1'b1;
          tail_nxt  = tail_r + 1'b1;
        end
        if (d_r == 3'd7) begin
          state_nxt = (head_r < tail_nxt) ? ST_PRD : ST_REC;
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = ST_NB;
        end
      end
      ST_IRD: begin
        if (i_r >= count_r) begin
          results_nxt = 1'b1;
          fetch_nxt   = '0;
          state_nxt   = ST_IDLE;
        end else begin
          l_raddr   = i_r[AW-1:0];
          state_nxt = ST_IWT;
        end
      end
      ST_IWT: begin
        key_nxt   = l_rdata;
        j_nxt     = i_r;
        state_nxt = ST_JRD;
      end
      ST_JRD: begin
        if (j_r == '0) begin
          l_we      = 1'b1;
          l_waddr   = '0;
          l_wdata   = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_IRD;
        end else begin
          l_raddr   = AW'(j_r - 1'b1);
          state_nxt = ST_JWT;
        end
      end
      ST_JWT: begin
        l_we    = 1'b1;
        l_waddr = j_r[AW-1:0];
        if (l_rdata > key_r) begin
          l_wdata   = l_rdata;
          j_nxt     = j_r - 1'b1;
          state_nxt = ST_JRD;
        end else begin
          l_wdata   = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_IRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      results_r   <= 1'b0;
      h_r         <= DRW'(clamp_dim(gccs_pkg::DIM_RESET, MAX_ROWS));
      w_r         <= DCW'(clamp_dim(gccs_pkg::DIM_RESET, MAX_COLS));
      load_r      <= '0;
      count_r     <= '0;
      fetch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      results_r   <= results_nxt;
      h_r         <= h_nxt;
      w_r         <= w_nxt;
      load_r      <= load_nxt;
      count_r     <= count_nxt;
      fetch_r     <= fetch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lh_r <= lh_nxt;  lw_r <= lw_nxt;  n_r <= n_nxt;  s_r <= s_nxt;
    head_r <= head_nxt;  tail_r <= tail_nxt;  i_r <= i_nxt;  j_r <= j_nxt;
    sr_r <= sr_nxt;  sc_r <= sc_nxt;  cur_r_r <= cur_r_nxt;  cur_c_r <= cur_c_nxt;
    d_r <= d_nxt;  v_r <= v_nxt;  idx_r <= idx_nxt;
    nr_keep_r <= nr_keep_nxt;  nc_keep_r <= nc_keep_nxt;
    key_r <= key_nxt;  last_r <= last_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_region_value = 10'(l_rdata[LW-1:CW]);
  assign out_region_size  = 13'(l_rdata[CW-1:0]);
  assign out_last_pair    = last_r;

endmodule

[sv/gccs_checker.sv]
module gccs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_func,
  input logic out_valid,
  input logic out_last_pair
);

  // Every result follows a fetch word accepted in the cycle before.
  a_result_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_func == gccs_pkg::FUNC_FETCH))
    else $error("result without a preceding fetch");

  // A load word never yields a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == gccs_pkg::FUNC_LOAD) |=> !out_valid)
    else $error("result after a load word");

  // A result cycle keeps the block busy, so results never come back to back.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !out_valid)
    else $error("result strobe not isolated");

  // After reset the block is idle and silent.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // The last-pair flag only rises with a result.
  a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_last_pair) |-> out_valid)
    else $error("last flag raised without a result");

endmodule

bind grid_component_size_census gccs_checker u_gccs_checker (
  .clk, .rst_n, .start, .busy, .in_func, .out_valid, .out_last_pair
);
